// File: rtl/core/emboss_3x3_filter_macros.svh
// Assertion macros for the emboss filter core.
// Taken in by the top level; no other dependencies.
`ifndef EMBOSS_3X3_FILTER_MACROS_SVH
`define EMBOSS_3X3_FILTER_MACROS_SVH

// Same-edge implication, off while reset is asserted.
`define EMB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("emboss filter: same-cycle check failed");

// Next-edge implication, off while reset is asserted.
`define EMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("emboss filter: next-cycle check failed");

`endif

// File: rtl/core/emb_pkg.sv
// Shared types and constants of the emboss filter core.
// No dependencies; every module and interface of the block imports it.
package emb_pkg;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 3 * CH_W;
  localparam int unsigned CFG_IDX_W = 4;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Frame dimension limits and reset values
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(2);
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // Pixel: red in bits 7:0, green 15:8, blue 23:16
  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic            frame_last;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
  } cfg_item_t;

  // One line memory entry: column of rows r-1 and r-2
  typedef struct packed {
    pixel_t newer;
    pixel_t older;
  } line_t;

  // Control of one item in the read-modify-write stage
  typedef struct packed {
    logic   step;         // shift window and write back the column
    logic   from_line;    // drain: new pixel is the newer row (bottom mirror)
    logic   emit_edge;    // right-edge result from the window before the shift
    logic   emit_col;     // result from the window after the shift
    logic   top_mirror;   // top row taken from the bottom window row
    logic   left_mirror;  // left column taken from the right window column
    logic   last;         // final result of the frame
    pixel_t pix;
  } s1_ctrl_t;

  // Seven kernel taps (the two zero weights are left out)
  typedef struct packed {
    pixel_t tl;
    pixel_t tc;
    pixel_t ml;
    pixel_t mc;
    pixel_t mr;
    pixel_t bc;
    pixel_t br;
    logic   last;
  } taps_t;

endpackage

// File: rtl/core/emb_if.sv
// Valid/ready channel interfaces of the emboss filter: pixels in, results out, config.
// Depends on emb_pkg for the payload types.
interface emb_in_if import emb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface emb_out_if import emb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface emb_cfg_if import emb_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/emboss_3x3_filter.sv
// Top level of the 3x3 emboss filter over an RGB raster stream.
// Depends on emb_pkg, emb_if, emb_ctrl, emb_window, emb_kernel and the macros header.
//
// The block takes one item per clock while the output is not stalled: each
// pixel costs one read of its column from the line memory at the input transfer
// and one write-back of that column when the item leaves stage 1, and the two
// ports of that memory are what allow one item per cycle. A result of an item
// passes the stage 1 register, the stage 2 tap register and the output register
// in turn; in stream terms pixel n of a frame yields result n-W-1, and after the
// last pixel of a frame W+1 flush items drain the remaining results, the final
// one marked frame_last. Flush items outside a drain and pixels during a drain
// are dropped without a result. The line memory needs no clearing pass after
// reset. The config channel is always ready; a write to either register aborts
// the frame in progress and must only be issued while the block is idle.
`include "emboss_3x3_filter_macros.svh"
module emboss_3x3_filter import emb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input logic       clk,
  input logic       rst_n,
  emb_in_if.sink    in_ch,
  emb_out_if.source out_ch,
  emb_cfg_if.sink   cfg_ch
);

  // Limits that the 12-bit dimension registers can express
  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam int unsigned WMAX    = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int unsigned HMAX    = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int unsigned COL_W   = $clog2(WMAX);

  logic             cfg_we;
  logic             in_acc;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic             s1_valid;
  s1_ctrl_t         s1_ctrl;
  logic [COL_W-1:0] s1_addr;
  logic             s1_adv;
  logic             s2_valid;
  taps_t            taps;
  logic             out_free;

  // Channel transfers
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = !s1_valid || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  emb_ctrl #(
    .WMAX (WMAX),
    .HMAX (HMAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_ch.data.index),
    .cfg_value (cfg_ch.data.value),
    .in_acc    (in_acc),
    .in_item   (in_ch.data),
    .s1_adv    (s1_adv),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_ctrl   (s1_ctrl),
    .s1_addr   (s1_addr)
  );

  emb_window #(
    .DEPTH (WMAX)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_ctrl  (s1_ctrl),
    .s1_addr  (s1_addr),
    .out_free (out_free),
    .s1_adv   (s1_adv),
    .s2_valid (s2_valid),
    .taps     (taps)
  );

  emb_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .taps      (taps),
    .out_ready (out_ch.ready),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.data)
  );

  // A column read always belongs to a stepping item in the next stage
  `EMB_ASSERT_NEXT(a_read_feeds_step, clk, rst_n, rd_en, s1_valid && s1_ctrl.step)
  // An item gives at most one result
  `EMB_ASSERT_IMPL(a_single_emit, clk, rst_n, s1_valid, !(s1_ctrl.emit_edge && s1_ctrl.emit_col))
  // A stalled read-modify-write keeps its column
  `EMB_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid && !s1_adv, s1_valid && $stable(s1_addr))
  // Captured taps wait unchanged for the output register
  `EMB_ASSERT_NEXT(a_taps_hold, clk, rst_n, s2_valid && !out_free, s2_valid && $stable(taps))

endmodule

// File: rtl/core/emb_ctrl.sv
// Frame sequencer: config registers, column/row/drain counters, line memory read issue.
// Depends on emb_pkg; feeds emb_window with the read-modify-write stage.
module emb_ctrl import emb_pkg::*; #(
  parameter int unsigned WMAX = 2048,
  parameter int unsigned HMAX = 2048,
  localparam int unsigned COL_W  = $clog2(WMAX),
  localparam int unsigned ROW_W  = $clog2(HMAX),
  localparam int unsigned PEND_W = $clog2(WMAX + 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_value,
  input  logic                 in_acc,
  input  in_item_t             in_item,
  input  logic                 s1_adv,
  output logic                 rd_en,
  output logic [COL_W-1:0]     rd_addr,
  output logic                 s1_valid,
  output s1_ctrl_t             s1_ctrl,
  output logic [COL_W-1:0]     s1_addr
);

  localparam logic [DIM_W-1:0] W_HI = DIM_W'(WMAX);
  localparam logic [DIM_W-1:0] H_HI = DIM_W'(HMAX);

  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  s1_ctrl_t          s1_ctrl_r;
  logic [COL_W-1:0]  s1_addr_r;

  logic [DIM_W-1:0] w, h, col_x, row_x, col_inc, row_inc, row_eff;
  logic is_pix, pend_zero, pend_one, col_in, row_in, col_zero;
  logic pix_ok, fl_last, fl_abort, fl_step, step, load_s1;
  s1_ctrl_t s1_new;

  // Effective frame size, saturated to the supported range
  always_comb begin
    w = (width_r < DIM_MIN) ? DIM_MIN : ((width_r > W_HI) ? W_HI : width_r);
    h = (height_r < DIM_MIN) ? DIM_MIN : ((height_r > H_HI) ? H_HI : height_r);
  end

  // Item classification
  always_comb begin
    col_x     = DIM_W'(col_r);
    row_x     = DIM_W'(row_r);
    col_inc   = col_x + DIM_W'(1);
    row_inc   = row_x + DIM_W'(1);
    is_pix    = (in_item.opcode == OP_PIXEL);
    pend_zero = (pend_r == '0);
    pend_one  = (pend_r == PEND_W'(1));
    col_in    = (col_x < w);
    row_in    = (row_x < h);
    col_zero  = (col_r == '0);
    pix_ok    = is_pix && pend_zero && col_in && row_in;
    fl_last   = !is_pix && pend_one;
    fl_abort  = !is_pix && !pend_zero && !pend_one && !col_in;
    fl_step   = !is_pix && !pend_zero && !pend_one && col_in;
    step      = pix_ok || fl_step;
    // drain steps run as the virtual row below the frame
    row_eff   = pix_ok ? row_x : h;
    load_s1   = in_acc && (step || fl_last);
  end

  // Stage control for the accepted item
  always_comb begin
    s1_new.step        = step;
    s1_new.from_line   = fl_step;
    s1_new.emit_edge   = (step && col_zero && (row_eff >= DIM_W'(2))) || fl_last;
    s1_new.emit_col    = step && !col_zero && (row_eff >= DIM_W'(1));
    s1_new.top_mirror  = step && (col_zero ? (row_eff == DIM_W'(2)) : (row_eff == DIM_W'(1)));
    s1_new.left_mirror = (col_r == COL_W'(1));
    s1_new.last        = fl_last;
    s1_new.pix         = {in_item.in_blue, in_item.in_green, in_item.in_red};
  end

  // Counter and register updates; a register write aborts the frame
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pend_nxt   = pend_r;
    if (cfg_we && (cfg_idx == CFG_IMAGE_WIDTH || cfg_idx == CFG_IMAGE_HEIGHT)) begin
      if (cfg_idx == CFG_IMAGE_WIDTH) begin
        width_nxt = cfg_value;
      end else begin
        height_nxt = cfg_value;
      end
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (in_acc) begin
      if (pix_ok) begin
        if (col_inc == w) begin
          col_nxt = '0;
          if (row_inc == h) begin
            row_nxt  = '0;
            pend_nxt = PEND_W'(w) + PEND_W'(1);
          end else begin
            row_nxt = row_inc[ROW_W-1:0];
          end
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end else if (fl_step) begin
        col_nxt  = col_inc[COL_W-1:0];
        pend_nxt = pend_r - PEND_W'(1);
      end else if (fl_last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        pend_nxt = '0;
      end else if (fl_abort) begin
        col_nxt  = '0;
        pend_nxt = '0;
      end
    end
  end

  // Stage 1 occupancy: in_acc only comes while the stage is empty or advancing
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = load_s1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      pend_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pend_r     <= pend_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_ctrl_r <= s1_new;
      s1_addr_r <= col_r;
    end
  end

  // Column read is issued with the transfer, data lands with stage 1
  assign rd_en    = in_acc && step;
  assign rd_addr  = col_r;
  assign s1_valid = s1_valid_r;
  assign s1_ctrl  = s1_ctrl_r;
  assign s1_addr  = s1_addr_r;

endmodule

// File: rtl/core/emb_window.sv
// Line memory and 3x3 window: column read-modify-write, window shift, kernel tap capture.
// Depends on emb_pkg; fed by emb_ctrl, feeds emb_kernel.
module emb_window import emb_pkg::*; #(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              s1_valid,
  input  s1_ctrl_t          s1_ctrl,
  input  logic [ADDR_W-1:0] s1_addr,
  input  logic              out_free,
  output logic              s1_adv,
  output logic              s2_valid,
  output taps_t             taps
);

  line_t  line_mem [DEPTH];
  line_t  rd_line_r;
  line_t  wr_line;
  pixel_t win_r [3][3];
  pixel_t shifted [3][3];
  pixel_t new_px;
  pixel_t top_row [3];
  pixel_t top_now [3];
  logic   s2_valid_r, s2_valid_nxt;
  taps_t  taps_r, taps_new;
  logic   s1_emit, s2_free, mem_we;

  // Stage handshake: an item that gives no result never waits on stage 2
  always_comb begin
    s1_emit = s1_ctrl.emit_edge || s1_ctrl.emit_col;
    s2_free = !s2_valid_r || out_free;
    s1_adv  = s1_valid && (!s1_emit || s2_free);
    mem_we  = s1_adv && s1_ctrl.step;
  end

  // Line memory: the row r-1 entry moves to r-2, the new pixel becomes r-1.
  // Consecutive steps touch different columns, so the read of the next item
  // never meets the write-back of this one.
  always_comb begin
    new_px        = s1_ctrl.from_line ? rd_line_r.newer : s1_ctrl.pix;
    wr_line.newer = new_px;
    wr_line.older = rd_line_r.newer;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_addr] <= wr_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_line_r <= line_mem[rd_addr];
    end
  end

  // Window after the shift: new column enters on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shifted[k][0] = win_r[k][1];
      shifted[k][1] = win_r[k][2];
    end
    shifted[0][2] = rd_line_r.older;
    shifted[1][2] = rd_line_r.newer;
    shifted[2][2] = new_px;
  end

  // Tap selection with border mirroring
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      top_row[j] = s1_ctrl.top_mirror ? shifted[2][j] : shifted[0][j];
      top_now[j] = s1_ctrl.top_mirror ? win_r[2][j] : win_r[0][j];
    end
    if (s1_ctrl.emit_col) begin
      taps_new.tl = s1_ctrl.left_mirror ? top_row[2] : top_row[0];
      taps_new.tc = top_row[1];
      taps_new.ml = s1_ctrl.left_mirror ? shifted[1][2] : shifted[1][0];
      taps_new.mc = shifted[1][1];
      taps_new.mr = shifted[1][2];
      taps_new.bc = shifted[2][1];
      taps_new.br = shifted[2][2];
    end else begin
      // right edge: center is the last column, right neighbor repeats it
      taps_new.tl = top_now[1];
      taps_new.tc = top_now[2];
      taps_new.ml = win_r[1][1];
      taps_new.mc = win_r[1][2];
      taps_new.mr = win_r[1][2];
      taps_new.bc = win_r[2][2];
      taps_new.br = win_r[2][2];
    end
    taps_new.last = s1_ctrl.last;
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (mem_we) begin
      win_r <= shifted;
    end
  end

  // Stage 2 occupancy
  always_comb begin
    if (s1_adv && s1_emit) begin
      s2_valid_nxt = 1'b1;
    end else if (out_free) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      taps_r <= taps_new;
    end
  end

  assign s2_valid = s2_valid_r;
  assign taps     = taps_r;

endmodule

// File: rtl/core/emb_kernel.sv
// Emboss kernel arithmetic per channel with offset and clamp, plus the output register.
// Depends on emb_pkg; fed by emb_window.
module emb_kernel import emb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s2_valid,
  input  taps_t     taps,
  input  logic      out_ready,
  output logic      out_free,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_new;
  logic      s2_adv;

  // -2*tl - tc - ml + mc + mr + bc + 2*br + 128, clamped to 0..255
  function automatic logic [CH_W-1:0] emboss_ch(
    input logic [CH_W-1:0] tl,
    input logic [CH_W-1:0] tc,
    input logic [CH_W-1:0] ml,
    input logic [CH_W-1:0] mc,
    input logic [CH_W-1:0] mr,
    input logic [CH_W-1:0] bc,
    input logic [CH_W-1:0] br
  );
    logic [10:0]        pos;
    logic [9:0]         neg;
    logic signed [11:0] sum;
    logic [CH_W-1:0]    res;
    pos = 11'(mc) + 11'(mr) + 11'(bc) + {2'b00, br, 1'b0} + 11'd128;
    neg = {1'b0, tl, 1'b0} + 10'(tc) + 10'(ml);
    sum = $signed({1'b0, pos}) - $signed({2'b00, neg});
    if (sum < 0) begin
      res = '0;
    end else if (sum > 12'sd255) begin
      res = '1;
    end else begin
      res = sum[CH_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    out_item_new.out_red = emboss_ch(taps.tl[CH_W-1:0], taps.tc[CH_W-1:0],
                                     taps.ml[CH_W-1:0], taps.mc[CH_W-1:0],
                                     taps.mr[CH_W-1:0], taps.bc[CH_W-1:0],
                                     taps.br[CH_W-1:0]);
    out_item_new.out_green = emboss_ch(taps.tl[2*CH_W-1:CH_W], taps.tc[2*CH_W-1:CH_W],
                                       taps.ml[2*CH_W-1:CH_W], taps.mc[2*CH_W-1:CH_W],
                                       taps.mr[2*CH_W-1:CH_W], taps.bc[2*CH_W-1:CH_W],
                                       taps.br[2*CH_W-1:CH_W]);
    out_item_new.out_blue = emboss_ch(taps.tl[3*CH_W-1:2*CH_W], taps.tc[3*CH_W-1:2*CH_W],
                                      taps.ml[3*CH_W-1:2*CH_W], taps.mc[3*CH_W-1:2*CH_W],
                                      taps.mr[3*CH_W-1:2*CH_W], taps.bc[3*CH_W-1:2*CH_W],
                                      taps.br[3*CH_W-1:2*CH_W]);
    out_item_new.frame_last = taps.last;
  end

  // Output register: takes a new result whenever it is empty or being drained
  always_comb begin
    out_free = !out_valid_r || out_ready;
    s2_adv   = s2_valid && out_free;
    if (s2_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_item_r <= out_item_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
